@@ rtl/mbp_pkg.sv @@
package mbp_pkg;

  // Result kinds as they appear on the result channel.
  typedef enum logic [3:0] {
    KIND_NOTE_OFF    = 4'd0,
    KIND_NOTE_ON     = 4'd1,
    KIND_KEY_PRESS   = 4'd2,
    KIND_CONTROL     = 4'd3,
    KIND_PROGRAM     = 4'd4,
    KIND_CHAN_PRESS  = 4'd5,
    KIND_BEND        = 4'd6,
    KIND_COMMON      = 4'd7,
    KIND_REALTIME    = 4'd8,
    KIND_SYSEX_BYTE  = 4'd9,
    KIND_SYSEX_END   = 4'd10,
    KIND_SYSEX_ABORT = 4'd11
  } kind_t;

  // Status byte values and status nibbles.
  localparam logic [7:0] ST_SYSEX_START  = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END    = 8'hF7;
  localparam logic [7:0] ST_COMMON_FIRST = 8'hF1;
  localparam logic [7:0] ST_COMMON_LAST  = 8'hF6;
  localparam logic [7:0] ST_TIME_CODE    = 8'hF1;
  localparam logic [7:0] ST_SONG_POS     = 8'hF2;
  localparam logic [7:0] ST_SONG_SELECT  = 8'hF3;
  localparam logic [7:0] ST_RT_FIRST     = 8'hF8;
  localparam logic [7:0] ST_NONE         = 8'h00;

  localparam logic [3:0] NIB_NOTE_OFF   = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON    = 4'h9;
  localparam logic [3:0] NIB_KEY_PRESS  = 4'hA;
  localparam logic [3:0] NIB_CONTROL    = 4'hB;
  localparam logic [3:0] NIB_PROGRAM    = 4'hC;
  localparam logic [3:0] NIB_CHAN_PRESS = 4'hD;
  localparam logic [3:0] NIB_BEND       = 4'hE;

  localparam int STAMP_W = 63;

  // Default depth of the command queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 2;

  // One classified input byte: an optional SysEx abort followed by an
  // optional main result, both carrying the byte's timestamp.
  typedef struct packed {
    logic               has_abort;
    logic               has_main;
    kind_t              kind;
    logic [7:0]         status;
    logic [3:0]         channel;
    logic [6:0]         data1;
    logic [6:0]         data2;
    logic [STAMP_W-1:0] stamp;
  } cmd_t;

  // Number of data bytes that a status byte takes.
  function automatic logic [1:0] needed_data(input logic [7:0] s);
    logic [1:0] n;
    n = 2'd0;
    case (s[7:4])
      NIB_NOTE_OFF, NIB_NOTE_ON, NIB_KEY_PRESS, NIB_CONTROL, NIB_BEND: n = 2'd2;
      NIB_PROGRAM, NIB_CHAN_PRESS: n = 2'd1;
      default: begin
        if (s == ST_TIME_CODE || s == ST_SONG_SELECT) n = 2'd1;
        else if (s == ST_SONG_POS) n = 2'd2;
        else n = 2'd0;
      end
    endcase
    return n;
  endfunction

endpackage

@@ rtl/mbp_front.sv @@
module mbp_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [7:0]                  in_data_byte,
  input  logic [mbp_pkg::STAMP_W-1:0] in_time_stamp,
  output logic                        push,
  output mbp_pkg::cmd_t               cmd
);

  logic       in_sysex_r, in_sysex_nxt;
  logic [7:0] run_status_r, run_status_nxt;
  logic [1:0] pend_cnt_r, pend_cnt_nxt;
  logic [6:0] pend0_r, pend0_nxt;

  logic       take;
  logic       done;
  logic [7:0] b;
  logic [1:0] need;
  logic [1:0] cnt_inc;
  logic [6:0] d0;

  assign take = in_valid && in_ready;
  assign b    = in_data_byte;

  // Classify the byte and work out the parser state after it.
  always_comb begin
    in_sysex_nxt   = in_sysex_r;
    run_status_nxt = run_status_r;
    pend_cnt_nxt   = pend_cnt_r;
    pend0_nxt      = pend0_r;
    cmd            = '0;
    cmd.stamp      = in_time_stamp;
    done           = 1'b0;
    need           = mbp_pkg::needed_data(run_status_r);
    cnt_inc        = pend_cnt_r + 2'd1;
    d0             = (pend_cnt_r == 2'd0) ? b[6:0] : pend0_r;

    // Inside SysEx: payload, end, real-time, or an abort that falls through.
    if (in_sysex_r) begin
      if (b == mbp_pkg::ST_SYSEX_END) begin
        in_sysex_nxt = 1'b0;
        cmd.has_main = 1'b1;
        cmd.kind     = mbp_pkg::KIND_SYSEX_END;
        done         = 1'b1;
      end else if (b >= mbp_pkg::ST_RT_FIRST) begin
        cmd.has_main = 1'b1;
        cmd.kind     = mbp_pkg::KIND_REALTIME;
        cmd.status   = b;
        done         = 1'b1;
      end else if (!b[7]) begin
        cmd.has_main = 1'b1;
        cmd.kind     = mbp_pkg::KIND_SYSEX_BYTE;
        cmd.data1    = b[6:0];
        done         = 1'b1;
      end else begin
        in_sysex_nxt  = 1'b0;
        cmd.has_abort = 1'b1;
      end
    end

    // Ordinary byte handling.
    if (!done) begin
      if (b >= mbp_pkg::ST_RT_FIRST) begin
        cmd.has_main = 1'b1;
        cmd.kind     = mbp_pkg::KIND_REALTIME;
        cmd.status   = b;
      end else if (b == mbp_pkg::ST_SYSEX_START) begin
        in_sysex_nxt = 1'b1;
      end else if (b[7]) begin
        pend_cnt_nxt = 2'd0;
        if (mbp_pkg::needed_data(b) == 2'd0) begin
          run_status_nxt = mbp_pkg::ST_NONE;
          if (b >= mbp_pkg::ST_COMMON_FIRST && b <= mbp_pkg::ST_COMMON_LAST) begin
            cmd.has_main = 1'b1;
            cmd.kind     = mbp_pkg::KIND_COMMON;
            cmd.status   = b;
          end
        end else begin
          run_status_nxt = b;
        end
      end else if (run_status_r != mbp_pkg::ST_NONE && need != 2'd0 &&
                   pend_cnt_r < 2'd2) begin
        if (pend_cnt_r == 2'd0) pend0_nxt = b[6:0];
        pend_cnt_nxt = cnt_inc;
        if (cnt_inc >= need) begin
          // Message complete: the current byte is the last data byte.
          pend_cnt_nxt = 2'd0;
          cmd.has_main = 1'b1;
          cmd.status   = run_status_r;
          cmd.channel  = run_status_r[3:0];
          cmd.data1    = d0;
          cmd.data2    = b[6:0];
          case (run_status_r[7:4])
            mbp_pkg::NIB_NOTE_OFF:   cmd.kind = mbp_pkg::KIND_NOTE_OFF;
            mbp_pkg::NIB_NOTE_ON: begin
              cmd.kind = (b[6:0] == 7'd0) ? mbp_pkg::KIND_NOTE_OFF
                                          : mbp_pkg::KIND_NOTE_ON;
            end
            mbp_pkg::NIB_KEY_PRESS:  cmd.kind = mbp_pkg::KIND_KEY_PRESS;
            mbp_pkg::NIB_CONTROL:    cmd.kind = mbp_pkg::KIND_CONTROL;
            mbp_pkg::NIB_PROGRAM: begin
              cmd.kind  = mbp_pkg::KIND_PROGRAM;
              cmd.data2 = 7'd0;
            end
            mbp_pkg::NIB_CHAN_PRESS: begin
              cmd.kind  = mbp_pkg::KIND_CHAN_PRESS;
              cmd.data2 = 7'd0;
            end
            mbp_pkg::NIB_BEND:       cmd.kind = mbp_pkg::KIND_BEND;
            default: begin
              // System common with data; it also ends running status.
              cmd.kind       = mbp_pkg::KIND_COMMON;
              cmd.channel    = 4'd0;
              run_status_nxt = mbp_pkg::ST_NONE;
              if (run_status_r != mbp_pkg::ST_SONG_POS) cmd.data2 = 7'd0;
            end
          endcase
        end
      end
    end
  end

  assign push = take && (cmd.has_abort || cmd.has_main);

  // Parser state advances on every input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sysex_r   <= 1'b0;
      run_status_r <= mbp_pkg::ST_NONE;
      pend_cnt_r   <= 2'd0;
      pend0_r      <= 7'd0;
    end else if (take) begin
      in_sysex_r   <= in_sysex_nxt;
      run_status_r <= run_status_nxt;
      pend_cnt_r   <= pend_cnt_nxt;
      pend0_r      <= pend0_nxt;
    end
  end

endmodule

@@ rtl/mbp_queue.sv @@
module mbp_queue #(
  parameter int DEPTH = mbp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mbp_pkg::cmd_t push_data,
  input  logic          pop,
  output mbp_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mbp_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CW'(DEPTH));
  assign head  = mem_r[rd_ptr_r];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // Storage is written at the tail; no reset needed for the payload.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wrap_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= wrap_inc(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("command queue count exceeds depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("command queue popped while empty");

endmodule

@@ rtl/mbp_back.sv @@
module mbp_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mbp_pkg::cmd_t               head,
  input  logic                        empty,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [3:0]                  out_kind,
  output logic [7:0]                  out_status_byte,
  output logic [3:0]                  out_channel,
  output logic [6:0]                  out_first_data,
  output logic [6:0]                  out_second_data,
  output logic [mbp_pkg::STAMP_W-1:0] out_stamp_out,
  output logic                        out_last_of_run
);

  logic                        out_valid_r;
  logic                        phase_r, phase_nxt;
  logic [3:0]                  kind_r;
  logic [7:0]                  status_r;
  logic [3:0]                  channel_r;
  logic [6:0]                  data1_r, data2_r;
  logic [mbp_pkg::STAMP_W-1:0] stamp_r;
  logic                        last_r;

  logic load;
  logic emit_abort;

  // The output register takes a new result whenever it is empty or drained.
  assign load       = !out_valid_r || out_ready;
  assign emit_abort = head.has_abort && !phase_r;

  always_comb begin
    pop       = 1'b0;
    phase_nxt = phase_r;
    if (load && !empty) begin
      if (emit_abort) begin
        if (head.has_main) phase_nxt = 1'b1;
        else pop = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        pop       = 1'b1;
      end
    end
  end

  // Control: valid flag and the abort/main phase of the head command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) out_valid_r <= !empty;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load && !empty) begin
      stamp_r <= head.stamp;
      if (emit_abort) begin
        kind_r    <= mbp_pkg::KIND_SYSEX_ABORT;
        status_r  <= 8'd0;
        channel_r <= 4'd0;
        data1_r   <= 7'd0;
        data2_r   <= 7'd0;
        last_r    <= !head.has_main;
      end else begin
        kind_r    <= head.kind;
        status_r  <= head.status;
        channel_r <= head.channel;
        data1_r   <= head.data1;
        data2_r   <= head.data2;
        last_r    <= 1'b1;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_status_byte = status_r;
  assign out_channel     = channel_r;
  assign out_first_data  = data1_r;
  assign out_second_data = data2_r;
  assign out_stamp_out   = stamp_r;
  assign out_last_of_run = last_r;

  a_phase_abort: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (out_valid_r && kind_r == mbp_pkg::KIND_SYSEX_ABORT && !last_r))
    else $error("abort phase without a pending abort result");

  a_abort_then_common: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !last_r && out_ready) |=>
      (out_valid_r && last_r && kind_r == mbp_pkg::KIND_COMMON))
    else $error("non-final result not followed by its common message");

endmodule

@@ rtl/midi_byte_stream_parser.sv @@
// Channel   Ports                           Direction  Transfer
// input     in_data_byte, in_time_stamp     in         in_valid & in_ready
// result    out_kind .. out_last_of_run     out        out_valid & out_ready
//
// One byte is taken per cycle while the command queue has room; the front
// classifies it at its transfer, the queue stores it, and its first result
// is loaded from the queue head into the output register once that is free.
// A byte that ends a SysEx run with a zero-data common status gives two
// results, which leave in turn through the single output register.
// Reset clears the parser state, the queue pointers and the output valid flag at once.
// A stalled result channel fills the queue; the input then stalls.
module midi_byte_stream_parser #(
  parameter int QUEUE_DEPTH = mbp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_data_byte,
  input  logic [mbp_pkg::STAMP_W-1:0] in_time_stamp,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [3:0]                  out_kind,
  output logic [7:0]                  out_status_byte,
  output logic [3:0]                  out_channel,
  output logic [6:0]                  out_first_data,
  output logic [6:0]                  out_second_data,
  output logic [mbp_pkg::STAMP_W-1:0] out_stamp_out,
  output logic                        out_last_of_run
);

  logic          push, pop, empty, full;
  mbp_pkg::cmd_t cmd, head;

  assign in_ready = !full;

  mbp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_time_stamp (in_time_stamp),
    .push          (push),
    .cmd           (cmd)
  );

  mbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cmd),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  mbp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .empty           (empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_status_byte (out_status_byte),
    .out_channel     (out_channel),
    .out_first_data  (out_first_data),
    .out_second_data (out_second_data),
    .out_stamp_out   (out_stamp_out),
    .out_last_of_run (out_last_of_run)
  );

endmodule

@@ tb/midi_byte_stream_parser_test.sv @@
module midi_byte_stream_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbp_pkg::*;

  // Status bytes by testbench names; the package names F1 and F3 too, not F4, F5 or FF.
  localparam logic [7:0] ST_MTC_QF    = 8'hF1;
  localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
  localparam logic [7:0] ST_UNDEF_F4  = 8'hF4;
  localparam logic [7:0] ST_UNDEF_F5  = 8'hF5;
  localparam logic [7:0] ST_SYS_RESET = 8'hFF;

  localparam int RANDOM_BYTES = 1750;
  localparam int CALM_TAIL    = 120;

  // One received byte with its time of arrival.
  typedef struct packed {
    logic [7:0]         b;
    logic [STAMP_W-1:0] ts;
  } midi_in_t;

  // One decoded message as it leaves the result channel.
  typedef struct packed {
    kind_t              kind;
    logic [7:0]         status;
    logic [3:0]         chan;
    logic [6:0]         d1;
    logic [6:0]         d2;
    logic [STAMP_W-1:0] stamp;
    logic               last;
  } midi_msg_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_data_byte = '0;
  logic [STAMP_W-1:0]  in_time_stamp = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [3:0]          out_kind;
  logic [7:0]          out_status_byte;
  logic [3:0]          out_channel;
  logic [6:0]          out_first_data;
  logic [6:0]          out_second_data;
  logic [STAMP_W-1:0]  out_stamp_out;
  logic                out_last_of_run;

  midi_in_t  byte_q[$];
  midi_msg_t msg_q[$];

  // Parser state as the testbench tracks it.
  bit         sysex_open = 1'b0;
  logic [7:0] cur_status = ST_NONE;
  logic [1:0] held_count = '0;
  logic [6:0] held_data [2] = '{7'd0, 7'd0};

  int       errors = 0;
  int       bytes_sent = 0;
  int       msgs_checked = 0;
  bit       in_accepted = 1'b0;
  bit       calm = 1'b0;
  bit       burst_mode = 1'b1;
  int       in_gap = 0;
  int       out_gap = 0;
  midi_in_t next_in;
  bit       chan_active = 1'b0;
  logic [7:0] gen_status = ST_NONE;

  midi_byte_stream_parser uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_time_stamp   (in_time_stamp),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_status_byte (out_status_byte),
    .out_channel     (out_channel),
    .out_first_data  (out_first_data),
    .out_second_data (out_second_data),
    .out_stamp_out   (out_stamp_out),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Number of data bytes that follow a status byte.
  function automatic logic [1:0] data_len(input logic [7:0] s);
    if (s[7:4] == NIB_PROGRAM || s[7:4] == NIB_CHAN_PRESS) return 2'd1;
    if (s[7:4] >= NIB_NOTE_OFF && s[7:4] <= NIB_BEND) return 2'd2;
    if (s == ST_MTC_QF || s == ST_SONG_SEL) return 2'd1;
    if (s == ST_SONG_POS) return 2'd2;
    return 2'd0;
  endfunction

  function automatic midi_msg_t make_msg(input kind_t k, input logic [7:0] st,
                                         input logic [3:0] ch, input logic [6:0] a,
                                         input logic [6:0] c,
                                         input logic [STAMP_W-1:0] ts);
    midi_msg_t m;
    m.kind   = k;
    m.status = st;
    m.chan   = ch;
    m.d1     = a;
    m.d2     = c;
    m.stamp  = ts;
    m.last   = 1'b0;
    return m;
  endfunction

  // Builds the message that a complete status plus held data forms.
  function automatic midi_msg_t complete_msg(input logic [7:0] s,
                                             input logic [STAMP_W-1:0] ts,
                                             output bit ok);
    midi_msg_t m;
    ok = 1'b1;
    m = make_msg(KIND_COMMON, s, 4'd0, 7'd0, 7'd0, ts);
    case (s[7:4])
      NIB_NOTE_OFF:   m = make_msg(KIND_NOTE_OFF, s, s[3:0], held_data[0], held_data[1], ts);
      NIB_NOTE_ON: begin
        // A note-on at velocity zero counts as a note-off.
        if (held_data[1] == 7'd0)
          m = make_msg(KIND_NOTE_OFF, s, s[3:0], held_data[0], 7'd0, ts);
        else
          m = make_msg(KIND_NOTE_ON, s, s[3:0], held_data[0], held_data[1], ts);
      end
      NIB_KEY_PRESS:  m = make_msg(KIND_KEY_PRESS, s, s[3:0], held_data[0], held_data[1], ts);
      NIB_CONTROL:    m = make_msg(KIND_CONTROL, s, s[3:0], held_data[0], held_data[1], ts);
      NIB_PROGRAM:    m = make_msg(KIND_PROGRAM, s, s[3:0], held_data[0], 7'd0, ts);
      NIB_CHAN_PRESS: m = make_msg(KIND_CHAN_PRESS, s, s[3:0], held_data[0], 7'd0, ts);
      NIB_BEND:       m = make_msg(KIND_BEND, s, s[3:0], held_data[0], held_data[1], ts);
      default: begin
        if (s >= ST_COMMON_FIRST && s <= ST_COMMON_LAST)
          m = make_msg(KIND_COMMON, s, 4'd0,
                       (data_len(s) != 2'd0) ? held_data[0] : 7'd0,
                       (s == ST_SONG_POS) ? held_data[1] : 7'd0, ts);
        else
          ok = 1'b0;
      end
    endcase
    return m;
  endfunction

  // Advances the tracked parser state by one byte and queues its messages.
  task automatic parse_byte(input logic [7:0] b, input logic [STAMP_W-1:0] ts);
    midi_msg_t  res [2];
    int         n;
    bit         ok;
    bit         done;
    logic [1:0] need;
    n = 0;
    done = 1'b0;
    if (sysex_open) begin
      done = 1'b1;
      if (b == ST_SYSEX_END) begin
        sysex_open = 1'b0;
        res[n] = make_msg(KIND_SYSEX_END, ST_NONE, 4'd0, 7'd0, 7'd0, ts);
        n++;
      end else if (b >= ST_RT_FIRST) begin
        res[n] = make_msg(KIND_REALTIME, b, 4'd0, 7'd0, 7'd0, ts);
        n++;
      end else if (!b[7]) begin
        res[n] = make_msg(KIND_SYSEX_BYTE, ST_NONE, 4'd0, b[6:0], 7'd0, ts);
        n++;
      end else begin
        // Any other status cuts the run short and is then parsed normally.
        sysex_open = 1'b0;
        res[n] = make_msg(KIND_SYSEX_ABORT, ST_NONE, 4'd0, 7'd0, 7'd0, ts);
        n++;
        done = 1'b0;
      end
    end
    if (!done) begin
      if (b >= ST_RT_FIRST) begin
        res[n] = make_msg(KIND_REALTIME, b, 4'd0, 7'd0, 7'd0, ts);
        n++;
      end else if (b == ST_SYSEX_START) begin
        sysex_open = 1'b1;
      end else if (b[7]) begin
        held_count = 2'd0;
        if (data_len(b) == 2'd0) begin
          cur_status = ST_NONE;
          res[n] = complete_msg(b, ts, ok);
          if (ok) n++;
        end else begin
          cur_status = b;
        end
      end else if (cur_status != ST_NONE) begin
        need = data_len(cur_status);
        if (need != 2'd0 && held_count < 2'd2) begin
          held_data[held_count[0]] = b[6:0];
          held_count = held_count + 2'd1;
          if (held_count >= need) begin
            res[n] = complete_msg(cur_status, ts, ok);
            if (ok) n++;
            held_count = 2'd0;
            if (cur_status >= ST_COMMON_FIRST && cur_status <= ST_COMMON_LAST)
              cur_status = ST_NONE;
          end
        end
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) msg_q.push_back(res[i]);
  endtask

  function automatic logic [STAMP_W-1:0] rand_stamp();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 31))
      0: return '0;
      1: return '1;
      default: return w[STAMP_W-1:0];
    endcase
  endfunction

  task automatic add_byte_ts(input logic [7:0] b, input logic [STAMP_W-1:0] ts);
    midi_in_t it;
    it.b = b;
    it.ts = ts;
    byte_q.push_back(it);
  endtask

  task automatic add_byte(input logic [7:0] b);
    add_byte_ts(b, rand_stamp());
  endtask

  // Now and then a real-time byte lands in the middle of a message.
  task automatic maybe_realtime();
    if ($urandom_range(0, 11) == 0) add_byte(8'(ST_RT_FIRST + $urandom_range(0, 7)));
  endtask

  task automatic build_directed();
    add_byte_ts(8'h40, '0);                 // data with no running status
    add_byte_ts({NIB_NOTE_ON, 4'h0}, '1);
    add_byte(8'h3C);
    add_byte(8'h7F);
    add_byte(8'h3C);                        // running status, velocity zero
    add_byte(8'h00);
    add_byte({NIB_NOTE_OFF, 4'hF});
    add_byte(8'h00);
    add_byte(8'h7F);
    add_byte({NIB_KEY_PRESS, 4'h5});
    add_byte(8'h0A);
    add_byte(ST_RT_FIRST);                  // real-time between data bytes
    add_byte(8'h14);
    add_byte({NIB_CONTROL, 4'h3});
    add_byte(8'h07);
    add_byte(8'h64);
    add_byte({NIB_PROGRAM, 4'h9});
    add_byte(8'h05);
    add_byte({NIB_CHAN_PRESS, 4'hA});
    add_byte(8'h55);
    add_byte({NIB_BEND, 4'hC});
    add_byte(8'h00);
    add_byte(8'h40);
    add_byte(ST_SONG_POS);
    add_byte(8'h01);
    add_byte(8'h02);
    add_byte(ST_COMMON_LAST);               // zero-data common
    add_byte(ST_SYSEX_END);                 // end marker outside SysEx
    add_byte(ST_SYSEX_START);
    add_byte(8'h7F);
    add_byte(ST_SYS_RESET);                 // real-time inside SysEx
    add_byte(ST_SYSEX_END);
    add_byte(ST_SYSEX_START);
    add_byte(8'h00);
    add_byte(ST_COMMON_LAST);               // abort followed by a common message
  endtask

  // Mostly well-formed messages with random content, plus some noise.
  task automatic build_random();
    int         total;
    int         pick;
    int         len;
    logic [1:0] nd;
    logic [7:0] s;
    logic [7:0] commons [6];
    commons = '{ST_MTC_QF, ST_SONG_POS, ST_SONG_SEL, ST_UNDEF_F4, ST_UNDEF_F5,
                ST_COMMON_LAST};
    total = byte_q.size() + RANDOM_BYTES;
    while (byte_q.size() < total) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if (!chan_active || $urandom_range(0, 9) < 6) begin
          gen_status = {4'(NIB_NOTE_OFF + $urandom_range(0, 6)), 4'($urandom_range(0, 15))};
          add_byte(gen_status);
          chan_active = 1'b1;
        end
        nd = data_len(gen_status);
        for (int k = 0; k < nd; k++) begin
          maybe_realtime();
          // A few messages are cut short by whatever comes next.
          if (k == nd - 1 && $urandom_range(0, 19) == 0) break;
          if (k == 1 && $urandom_range(0, 3) == 0) add_byte(8'h00);
          else add_byte(8'($urandom_range(0, 127)));
        end
      end else if (pick < 70) begin
        s = commons[$urandom_range(0, 5)];
        add_byte(s);
        nd = data_len(s);
        for (int k = 0; k < nd; k++) begin
          maybe_realtime();
          add_byte(8'($urandom_range(0, 127)));
        end
        chan_active = 1'b0;
      end else if (pick < 85) begin
        add_byte(ST_SYSEX_START);
        len = $urandom_range(0, 8);
        for (int k = 0; k < len; k++) begin
          maybe_realtime();
          add_byte(8'($urandom_range(0, 127)));
        end
        if ($urandom_range(0, 3) != 0) begin
          add_byte(ST_SYSEX_END);
        end else begin
          s = 8'($urandom_range(8'h80, 8'hF6));
          add_byte(s);
          chan_active = (s[7:4] != 4'hF);
          gen_status = s;
        end
      end else if (pick < 92) begin
        add_byte(8'(ST_RT_FIRST + $urandom_range(0, 7)));
      end else begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) add_byte(8'($urandom_range(0, 255)));
        chan_active = 1'b0;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result checking first, then prediction for the byte taken at this edge.
  always @(posedge clk) begin
    midi_msg_t m;
    in_accepted <= rst_n && in_valid && in_ready;
    calm <= (byte_q.size() < CALM_TAIL);
    if (rst_n && out_valid && out_ready) begin
      if (msg_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0h status %0h",
                 $time, out_kind, out_status_byte);
        errors++;
      end else begin
        m = msg_q.pop_front();
        check_field("kind", 64'(m.kind), 64'(out_kind));
        check_field("status_byte", 64'(m.status), 64'(out_status_byte));
        check_field("channel", 64'(m.chan), 64'(out_channel));
        check_field("first_data", 64'(m.d1), 64'(out_first_data));
        check_field("second_data", 64'(m.d2), 64'(out_second_data));
        check_field("stamp_out", 64'(m.stamp), 64'(out_stamp_out));
        check_field("last_of_run", 64'(m.last), 64'(out_last_of_run));
        msgs_checked++;
      end
    end
    if (rst_n && in_valid && in_ready) begin
      parse_byte(in_data_byte, in_time_stamp);
      bytes_sent++;
    end
  end

  // Input driver: a new byte goes out only after the previous transfer.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (byte_q.size() != 0 && !(burst_mode && !calm && $urandom_range(0, 7) == 0)) begin
        next_in = byte_q.pop_front();
        in_data_byte <= next_in.b;
        in_time_stamp <= next_in.ts;
        in_valid <= 1'b1;
      end else begin
        if (byte_q.size() != 0) in_gap = $urandom_range(0, 5);
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure in short bursts, switched off near the end.
  always @(negedge clk) begin
    if ($urandom_range(0, 149) == 0) burst_mode <= !burst_mode;
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (burst_mode && !calm && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    build_directed();
    build_random();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (byte_q.size() != 0 || in_valid) @(posedge clk);
    while (msg_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("Sent %0d MIDI bytes and checked %0d decoded messages.", bytes_sent, msgs_checked);
    $display("Traffic mixed running status, common, real-time and SysEx runs; %0d errors.",
             errors);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog for a stuck handshake.
  initial begin
    #4_000_000;
    $display("Timeout with %0d messages still expected.", msg_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mbp_pkg.sv
rtl/mbp_front.sv
rtl/mbp_queue.sv
rtl/mbp_back.sv
rtl/midi_byte_stream_parser.sv
tb/midi_byte_stream_parser_test.sv
